>>> src/ssr_pkg.sv
// Shared types and constants for the stream substring replace block.
package ssr_pkg;

    localparam int MaxPattern     = 8;
    localparam int MaxReplacement = 8;
    localparam int PendDepth      = MaxPattern - 1;
    localparam int JobBytes       = (MaxPattern > MaxReplacement) ? MaxPattern : MaxReplacement;
    localparam int CountW         = $clog2(JobBytes + 1);
    localparam int PendCntW       = $clog2(PendDepth + 1);
    localparam int QueueDepth     = 2;
    localparam int CfgIdxW        = 2;
    localparam int CfgDataW       = 64;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_PAT_BYTES = 2'd0,
        CFG_PAT_LEN   = 2'd1,
        CFG_REP_BYTES = 2'd2,
        CFG_REP_LEN   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [63:0] pat_bytes;
        logic [3:0]  pat_len;
        logic [63:0] rep_bytes;
        logic [3:0]  rep_len;
    } t_cfg;

    // One unit of work for the back end: emit the first count bytes, flag last.
    // count of zero with last set means a single byte-less result.
    typedef struct packed {
        logic [JobBytes*8-1:0] bytes;
        logic [CountW-1:0]     count;
        logic                  last;
    } t_job;

endpackage

>>> src/ssr_front.sv
// Front end: accepts input items, tracks pending match bytes, builds output jobs.
module ssr_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ssr_pkg::t_cfg i_cfg,
    input  logic          i_clear,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_data,
    input  logic          i_present,
    input  logic          i_eos,
    input  logic          i_q_full,
    output logic          o_push,
    output ssr_pkg::t_job o_job
);

    localparam int BufBytes = ssr_pkg::MaxPattern;

    logic [ssr_pkg::PendCntW-1:0] r_pend_cnt;
    logic [7:0]                   r_pend [ssr_pkg::PendDepth];

    logic                     accept;
    logic [3:0]               plen;
    logic [3:0]               rlen;
    logic [ssr_pkg::PendCntW-1:0] cnt;
    logic [3:0]               len;
    logic [7:0]               buf_b [2*BufBytes];
    logic [BufBytes*8-1:0]    buf_vec;
    logic [BufBytes*8-1:0]    pend_vec;
    logic [BufBytes*8-1:0]    rest_vec;
    logic [BufBytes:0]        ok;
    logic [3:0]               start;
    logic                     match;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        // clamp configured lengths
        if (i_cfg.pat_len == 4'd0) plen = 4'd1;
        else if (i_cfg.pat_len > 4'(ssr_pkg::MaxPattern)) plen = 4'(ssr_pkg::MaxPattern);
        else plen = i_cfg.pat_len;
        if (i_cfg.rep_len > 4'(ssr_pkg::MaxReplacement)) rlen = 4'(ssr_pkg::MaxReplacement);
        else rlen = i_cfg.rep_len;

        cnt = ({1'b0, r_pend_cnt} >= plen) ? '0 : r_pend_cnt;
        len = {1'b0, cnt} + 4'd1;

        pend_vec = '0;
        for (int i = 0; i < ssr_pkg::PendDepth; i++) pend_vec[i*8 +: 8] = r_pend[i];

        // pending bytes followed by the new byte
        for (int i = 0; i < 2*BufBytes; i++) buf_b[i] = 8'h00;
        for (int i = 0; i < BufBytes; i++) begin
            if (i == 32'(cnt)) buf_b[i] = i_data;
            else if (i < 32'(cnt)) buf_b[i] = pend_vec[i*8 +: 8];
        end
        for (int i = 0; i < BufBytes; i++) buf_vec[i*8 +: 8] = buf_b[i];

        // ok[s]: the tail starting at s is a prefix of the pattern
        for (int s = 0; s <= BufBytes; s++) begin
            ok[s] = 1'b1;
            for (int j = 0; j < BufBytes; j++) begin
                if ((s + j) < 32'(len) && buf_b[s+j] != i_cfg.pat_bytes[j*8 +: 8])
                    ok[s] = 1'b0;
            end
        end

        start = 4'(BufBytes);
        for (int s = BufBytes; s >= 0; s--) begin
            if (ok[s]) start = 4'(s);
        end

        match    = ok[0] && (len == plen);
        rest_vec = buf_vec >> {start, 3'b000};

        o_job.last = i_eos;
        if (i_present && match) begin
            o_job.bytes = i_cfg.rep_bytes;
            o_job.count = ssr_pkg::CountW'(rlen);
        end else if (i_present) begin
            o_job.bytes = buf_vec;
            o_job.count = i_eos ? ssr_pkg::CountW'(len) : ssr_pkg::CountW'(start);
        end else begin
            o_job.bytes = pend_vec;
            o_job.count = ssr_pkg::CountW'(cnt);
        end
        o_push = accept && (i_present || i_eos) && ((o_job.count != '0) || i_eos);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_cnt <= '0;
        end else if (i_clear) begin
            r_pend_cnt <= '0;
        end else if (accept) begin
            if (i_eos) r_pend_cnt <= '0;
            else if (i_present) r_pend_cnt <= match ? '0 : ssr_pkg::PendCntW'(len - start);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_present && !i_eos) begin
            for (int i = 0; i < ssr_pkg::PendDepth; i++) r_pend[i] <= rest_vec[i*8 +: 8];
        end
    end

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_clear |=> r_pend_cnt == '0)
        else $error("pending bytes survived a pattern write");

    a_end_flushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_eos |=> r_pend_cnt == '0)
        else $error("pending bytes left after end of string");

endmodule

>>> src/ssr_queue.sv
// Small job queue between the front end and the back end.
module ssr_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ssr_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_valid,
    output logic          o_full,
    output ssr_pkg::t_job o_job
);

    localparam int PtrW = $clog2(ssr_pkg::QueueDepth);
    localparam int CntW = $clog2(ssr_pkg::QueueDepth + 1);

    ssr_pkg::t_job   r_mem [ssr_pkg::QueueDepth];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CntW'(ssr_pkg::QueueDepth));
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= PtrW'((32'(r_wr_ptr) + 1) % ssr_pkg::QueueDepth);
            if (do_pop)  r_rd_ptr <= PtrW'((32'(r_rd_ptr) + 1) % ssr_pkg::QueueDepth);
            if (do_push && !do_pop) r_count <= r_count + CntW'(1);
            else if (do_pop && !do_push) r_count <= r_count - CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_job;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("job pushed into a full queue");

endmodule

>>> src/ssr_back.sv
// Back end: plays out one job as a run of output items.
module ssr_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  ssr_pkg::t_job i_q_job,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_byte,
    output logic          o_present,
    output logic          o_last
);

    logic                       r_active;
    ssr_pkg::t_job              r_job;
    logic [ssr_pkg::CountW-1:0] r_idx;

    logic handshake;
    logic final_item;
    logic [ssr_pkg::CountW:0] next_idx;

    assign next_idx   = {1'b0, r_idx} + (ssr_pkg::CountW+1)'(1);
    assign final_item = next_idx >= {1'b0, r_job.count};
    assign handshake  = r_active && i_ready;
    assign o_pop      = i_q_valid && (!r_active || (handshake && final_item));

    assign o_valid   = r_active;
    assign o_present = (r_job.count != '0);
    assign o_byte    = o_present ?
                       r_job.bytes[8*32'(r_idx[$clog2(ssr_pkg::JobBytes)-1:0]) +: 8] : 8'h00;
    assign o_last    = r_job.last && final_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_idx    <= '0;
        end else if (o_pop) begin
            r_active <= 1'b1;
            r_idx    <= '0;
        end else if (handshake) begin
            if (final_item) r_active <= 1'b0;
            else r_idx <= next_idx[ssr_pkg::CountW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_job <= i_q_job;
    end

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active && (r_job.count == '0) |-> r_job.last)
        else $error("byte-less result without end mark");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active && (r_job.count != '0) |-> r_idx < r_job.count)
        else $error("back end index ran past its job");

endmodule

>>> src/stream_substring_replace.sv
// Top level of the stream substring replace block.
// Replaces every leftmost, non-overlapping occurrence of the configured pattern (1..8 bytes)
// in a byte stream with the configured replacement (0..8 bytes). Input items carry one byte
// (s_tuser = byte present) and s_tlast marks the end of a string; bytes that could still start
// a match are held back and flushed at the end of the string. Each string closes with an
// output item marked m_tlast; a string whose output would be empty gives one byte-less item
// (m_tuser = 0) marked last. Timing: the front end takes one input item per cycle while the
// two-entry job queue has room; the back end emits one output item per cycle while m_tready
// is high, and an input item yields up to eight output items, so sustained throughput is set
// by the back end's emit counter. Configuration writes (i_cfg_we, register index, data) are
// registered; writing the pattern or its length drops any held bytes. Write only while the
// block is idle.
module stream_substring_replace (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [7:0] data_byte
    input  logic                         s_tuser,   // [0] byte_present
    input  logic                         s_tlast,   // end_of_string
    // output stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [7:0]                   m_tdata,   // [7:0] out_byte
    output logic                         m_tuser,   // [0] out_present
    output logic                         m_tlast,   // out_last
    // configuration write port
    input  logic                         i_cfg_we,
    input  logic [ssr_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [ssr_pkg::CfgDataW-1:0] i_cfg_data
);

    ssr_pkg::t_cfg r_cfg;
    logic          cfg_clear;

    logic          push;
    ssr_pkg::t_job push_job;
    logic          q_full;
    logic          q_valid;
    ssr_pkg::t_job q_job;
    logic          pop;

    // configuration registers; pattern writes also discard held bytes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pat_bytes <= '0;
            r_cfg.pat_len   <= 4'd1;
            r_cfg.rep_bytes <= '0;
            r_cfg.rep_len   <= '0;
        end else if (i_cfg_we) begin
            case (ssr_pkg::t_cfg_idx'(i_cfg_index))
                ssr_pkg::CFG_PAT_BYTES: r_cfg.pat_bytes <= i_cfg_data[63:0];
                ssr_pkg::CFG_PAT_LEN:   r_cfg.pat_len   <= i_cfg_data[3:0];
                ssr_pkg::CFG_REP_BYTES: r_cfg.rep_bytes <= i_cfg_data[63:0];
                ssr_pkg::CFG_REP_LEN:   r_cfg.rep_len   <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    assign cfg_clear = i_cfg_we &&
        ((ssr_pkg::t_cfg_idx'(i_cfg_index) == ssr_pkg::CFG_PAT_BYTES) ||
         (ssr_pkg::t_cfg_idx'(i_cfg_index) == ssr_pkg::CFG_PAT_LEN));

    ssr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_clear   (cfg_clear),
        .i_valid   (s_tvalid),
        .o_ready   (s_tready),
        .i_data    (s_tdata),
        .i_present (s_tuser),
        .i_eos     (s_tlast),
        .i_q_full  (q_full),
        .o_push    (push),
        .o_job     (push_job)
    );

    ssr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_job   (q_job)
    );

    ssr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_job   (q_job),
        .o_pop     (pop),
        .o_valid   (m_tvalid),
        .i_ready   (m_tready),
        .o_byte    (m_tdata),
        .o_present (m_tuser),
        .o_last    (m_tlast)
    );

endmodule

>>> verif/stream_substring_replace_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for stream_substring_replace: scoreboard predictor and stream traffic.
module stream_substring_replace_test;

    // One output item as the scoreboard expects it.
    typedef struct {
        bit [7:0] data;
        bit       present;
        bit       last;
    } t_out_item;

    // Predicts the rewritten stream and checks each output item against it, oldest first.
    class replace_scoreboard;
        bit [63:0] pat_bytes;
        bit [3:0]  pat_len;
        bit [63:0] rep_bytes;
        bit [3:0]  rep_len;
        bit [7:0]  held [0:7];
        int        held_cnt;
        t_out_item expected_out [$];
        int        errors;

        function new();
            pat_bytes = '0;
            pat_len   = 4'd1;
            rep_bytes = '0;
            rep_len   = 4'd0;
            held_cnt  = 0;
            errors    = 0;
        endfunction

        function void write_reg(ssr_pkg::t_cfg_idx idx, bit [63:0] v);
            case (idx)
                ssr_pkg::CFG_PAT_BYTES: begin
                    pat_bytes = v;
                    held_cnt  = 0;
                end
                ssr_pkg::CFG_PAT_LEN: begin
                    pat_len  = v[3:0];
                    held_cnt = 0;
                end
                ssr_pkg::CFG_REP_BYTES: rep_bytes = v;
                ssr_pkg::CFG_REP_LEN:   rep_len   = v[3:0];
                default: ;
            endcase
        endfunction

        // True when s[from +: n] equals the first n pattern bytes.
        function bit starts_pattern(bit [7:0] s [0:8], int from, int n);
            for (int k = 0; k < n; k++) begin
                if (s[from + k] != pat_bytes[8*k +: 8]) return 1'b0;
            end
            return 1'b1;
        endfunction

        function void push_byte(bit [7:0] d, bit p);
            t_out_item r;
            r.data    = d;
            r.present = p;
            r.last    = 1'b0;
            expected_out.push_back(r);
        endfunction

        function void predict_item(bit [7:0] d, bit present, bit last);
            bit [7:0] s [0:8];
            int plen;
            int rlen;
            int len;
            int start;
            int n;
            plen = (pat_len == 0) ? 1 :
                   (pat_len > ssr_pkg::MaxPattern) ? ssr_pkg::MaxPattern : int'(pat_len);
            rlen = (rep_len > ssr_pkg::MaxReplacement) ? ssr_pkg::MaxReplacement : int'(rep_len);
            n = 0;
            if (held_cnt >= plen) held_cnt = 0;
            if (present) begin
                for (int i = 0; i < held_cnt; i++) s[i] = held[i];
                s[held_cnt] = d;
                len = held_cnt + 1;
                start = 0;
                if (len == plen && starts_pattern(s, 0, len)) begin
                    // full match: swap in the replacement, nothing stays held
                    for (int i = 0; i < rlen; i++) push_byte(rep_bytes[8*i +: 8], 1'b1);
                    n += rlen;
                    start = len;
                end else begin
                    // release bytes from the front until the rest could still match
                    while (start < len && !starts_pattern(s, start, len - start)) begin
                        push_byte(s[start], 1'b1);
                        n++;
                        start++;
                    end
                end
                held_cnt = len - start;
                for (int i = 0; i < held_cnt; i++) held[i] = s[start + i];
            end
            if (last) begin
                for (int i = 0; i < held_cnt; i++) push_byte(held[i], 1'b1);
                n += held_cnt;
                held_cnt = 0;
                if (n == 0) push_byte(8'h00, 1'b0);
                expected_out[expected_out.size() - 1].last = 1'b1;
            end
        endfunction

        function void compare_output(bit [7:0] d, bit p, bit l);
            t_out_item e;
            if (expected_out.size() == 0) begin
                errors++;
                $display("%0t: unexpected item: expected none, got byte %02h present %0b last %0b",
                         $time, d, p, l);
                return;
            end
            e = expected_out.pop_front();
            if (e.data != d) begin
                errors++;
                $display("%0t: out_byte expected %02h got %02h", $time, e.data, d);
            end
            if (e.present != p) begin
                errors++;
                $display("%0t: out_present expected %0b got %0b", $time, e.present, p);
            end
            if (e.last != l) begin
                errors++;
                $display("%0t: out_last expected %0b got %0b", $time, e.last, l);
            end
        endfunction
    endclass

    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         s_tvalid    = 1'b0;
    logic [7:0]                   s_tdata     = '0;   // [7:0] data_byte
    logic                         s_tuser     = 1'b0; // [0] byte_present
    logic                         s_tlast     = 1'b0; // end_of_string
    logic                         m_tready    = 1'b0;
    logic                         i_cfg_we    = 1'b0;
    logic [ssr_pkg::CfgIdxW-1:0]  i_cfg_index = '0;
    logic [ssr_pkg::CfgDataW-1:0] i_cfg_data  = '0;
    logic                         s_tready;
    logic                         m_tvalid;
    logic [7:0]                   m_tdata;   // [7:0] out_byte
    logic                         m_tuser;   // [0] out_present
    logic                         m_tlast;   // out_last

    replace_scoreboard sb = new();

    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int hold_off      = 0;   // cycles the sink keeps m_tready low, counted down below

    stream_substring_replace uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Sink: values read right after the edge are the ones the block saw at it.
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) sb.compare_output(m_tdata, m_tuser, m_tlast);
        if (hold_off > 0) begin
            m_tready <= 1'b0;
            hold_off--;
        end else begin
            m_tready <= (int'($urandom_range(99)) >= snk_stall_pct);
        end
    end

    // Offer one item, with random idle cycles first; returns at the accepting edge.
    task automatic send_item(bit [7:0] d, bit p, bit l);
        if (int'($urandom_range(99)) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge i_clk); while (int'($urandom_range(99)) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= p;
        s_tlast  <= l;
        do @(posedge i_clk); while (!s_tready);
        sb.predict_item(d, p, l);
    endtask

    task automatic send_text(string t, bit close);
        for (int i = 0; i < t.len(); i++) send_item(t[i], 1'b1, close && i == t.len() - 1);
    endtask

    // Stop sending, let every expected item arrive, then allow for zero-result items in flight.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.expected_out.size() != 0);
        repeat (12) @(posedge i_clk);
    endtask

    // Only called while idle; the write enable drops for a cycle between writes.
    task automatic set_reg(ssr_pkg::t_cfg_idx idx, logic [63:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_reg(idx, v);
        @(posedge i_clk);
    endtask

    // One random string built mostly from pattern pieces; returns the counted items.
    task automatic send_string(logic [63:0] pat, int ep, output int cnt);
        bit [7:0] str [$];
        int r;
        int n;
        bit end_only;
        repeat ($urandom_range(0, 5)) begin
            r = $urandom_range(99);
            if (r < 35) begin
                for (int k = 0; k < ep; k++) str.push_back(pat[8*k +: 8]);
            end else if (r < 55) begin
                n = $urandom_range(1, ep);
                for (int k = 0; k < n; k++) str.push_back(pat[8*k +: 8]);
            end else if (r < 85) begin
                str.push_back(pat[8*$urandom_range(0, ep - 1) +: 8]);
            end else begin
                str.push_back(8'($urandom_range(0, 255)));
            end
        end
        end_only = (str.size() == 0) || ($urandom_range(3) == 0);
        for (int k = 0; k < str.size(); k++) begin
            // occasional item with neither byte nor end mark
            if ($urandom_range(19) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(str[k], 1'b1, !end_only && k == str.size() - 1);
        end
        if (end_only) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        cnt = str.size() + int'(end_only);
    endtask

    initial begin
        int sent;
        int cnt;
        int plc;
        int rlc;
        int ep;
        logic [63:0] pat;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: pattern is one zero byte, empty replacement deletes it.
        send_item(8'h00, 1'b1, 1'b1);          // whole output deleted -> byte-less last item
        send_item(8'hFF, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hAA, 1'b0, 1'b1);          // end-only item
        send_item(8'h5A, 1'b0, 1'b0);          // neither byte nor end: no effect

        drain();
        set_reg(ssr_pkg::CFG_PAT_BYTES, 64'h0000_0000_0063_6261);   // "abc"
        set_reg(ssr_pkg::CFG_PAT_LEN, 64'd3);
        set_reg(ssr_pkg::CFG_REP_BYTES, 64'h4847_4645_4443_4241);   // "ABCDEFGH"
        set_reg(ssr_pkg::CFG_REP_LEN, 64'd8);
        send_text("aabcab", 1'b0);
        send_item(8'h00, 1'b0, 1'b1);          // flushes the held "ab"

        // Pattern rewritten while bytes are held: they are dropped.
        send_text("ab", 1'b0);
        drain();
        set_reg(ssr_pkg::CFG_PAT_LEN, 64'd2);
        send_item(8'h00, 1'b0, 1'b1);
        send_text("xaby", 1'b1);

        // Oversized lengths clamp to 8; all-ones pattern, replacement with 00 and FF bytes.
        drain();
        set_reg(ssr_pkg::CFG_PAT_BYTES, 64'hFFFF_FFFF_FFFF_FFFF);
        set_reg(ssr_pkg::CFG_PAT_LEN, 64'd15);
        set_reg(ssr_pkg::CFG_REP_BYTES, 64'h00FF_5AA5_C33C_0FF0);
        set_reg(ssr_pkg::CFG_REP_LEN, 64'd15);
        for (int i = 0; i < 8; i++) send_item(8'hFF, 1'b1, i == 7);

        // Random phases, each with its own settings and idle pattern.
        for (int ph = 0; ph < 6; ph++) begin
            drain();
            case (ph)
                0: begin plc = 1;  rlc = 0;  end
                1: begin plc = 8;  rlc = 8;  end
                2: begin plc = 0;  rlc = 15; end
                3: begin plc = 15; rlc = 1;  end
                default: begin
                    plc = $urandom_range(1, 8);
                    rlc = $urandom_range(0, 8);
                end
            endcase
            ep  = (plc == 0) ? 1 : (plc > ssr_pkg::MaxPattern) ? ssr_pkg::MaxPattern : plc;
            pat = {$urandom, $urandom};
            set_reg(ssr_pkg::CFG_PAT_BYTES, pat);
            set_reg(ssr_pkg::CFG_PAT_LEN, 64'(plc));
            set_reg(ssr_pkg::CFG_REP_BYTES, {$urandom, $urandom});
            set_reg(ssr_pkg::CFG_REP_LEN, 64'(rlc));
            case (ph % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 47; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 47; end
                default: begin src_idle_pct = 6; snk_stall_pct = 6; end
            endcase
            // long sink hold while the source keeps offering: backs up into s_tready
            if (ph == 4) hold_off = 300;
            sent = 0;
            while (sent < 32) begin
                send_string(pat, ep, cnt);
                sent += cnt;
                // source pauses until all outstanding items are out
                if (ph == 5 && $urandom_range(3) == 0) drain();
            end
        end

        drain();
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
